/* hw/rtl/modbus_read_request_checker_core_defines.svh */
// assertion macros for the modbus read request checker
// used by the checker file; no other dependencies
`ifndef MODBUS_READ_REQUEST_CHECKER_CORE_DEFINES_SVH
`define MODBUS_READ_REQUEST_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define MRRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, quiet during reset
`define MRRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/mrrc_pkg.sv */
// shared types, constants and crc function for the modbus read request checker
// no dependencies
package mrrc_pkg;

   localparam logic [2:0]  FRAME_LAST_POS = 3'd7;
   localparam logic [2:0]  CRC_BYTES      = 3'd6;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [7:0]  FUNC_READ      = 8'h03;
   localparam logic [7:0]  QTY_READ       = 8'h02;
   localparam logic [15:0] REG_FIRST      = 16'h0014;
   localparam logic [15:0] REG_LAST       = 16'h0053;
   localparam logic [7:0]  STATION_RESET  = 8'h01;
   localparam logic [3:0]  CHANNEL_BIAS   = 4'd8;

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_ADDR_MISMATCH = 3'd1,
      STATUS_CRC_ERROR     = 3'd2,
      STATUS_BAD_FUNCTION  = 3'd3,
      STATUS_REG_RANGE     = 3'd4
   } status_type;

   // frame view handed from the accumulator to the checker
   typedef struct packed {
      logic        last;
      logic [7:0]  station;
      logic [7:0]  function_code;
      logic [15:0] register_address;
      logic [7:0]  quantity_low;
      logic [15:0] crc_received;
      logic [15:0] crc_computed;
   } frame_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] register_address;
      logic [1:0]  sensor_kind;
      logic [3:0]  channel;
   } result_type;

   // one byte of the reflected modbus crc-16
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* hw/rtl/mrrc_if.sv */
// valid/ready channel interfaces for request bytes and check results
// no dependencies
interface mrrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] register_address;
   logic [1:0]  sensor_kind;
   logic [3:0]  channel;

   modport source (output valid, output status, output register_address,
                   output sensor_kind, output channel, input ready);
   modport sink (input valid, input status, input register_address,
                 input sensor_kind, input channel, output ready);
endinterface

/* hw/rtl/modbus_read_request_checker_core.sv */
// modbus rtu read request checker, top level
// depends on mrrc_pkg, mrrc_if, mrrc_frame_acc and mrrc_result_chk
//
// usage:
//  - req_chan carries one received byte per transaction; eight bytes make
//    one read request frame, with no resync other than reset
//  - rsp_chan carries one check result per frame: status, register address,
//    sensor kind and channel (kind and channel are zero unless status is ok)
//  - csr_write_enable/csr_write_data load the station address (reset 1);
//    write it only while no frame is in progress
//  - throughput: one byte per cycle while rsp_chan is not stalled; the
//    byte crc update is combinational logic between the input register
//    and the frame state; the eighth byte of a frame sits in the input
//    register, then the result is registered
//  - reset clears the byte position and both valid flags, presets the crc
//    and restores the station address; the first byte after it starts a frame
//  - when rsp_chan stalls the result holds; bytes of the next frame keep
//    flowing, only its eighth byte waits in the input register, and then
//    req_chan.ready drops until the held result is taken
module modbus_read_request_checker_core
   import mrrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mrrc_req_if.sink   req_chan,
   mrrc_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_result_ff;
   logic [7:0] station_ff;
   logic       req_take;
   logic       out_free;
   logic       advance;
   frame_type  frame;
   result_type result;

   // byte position and crc state
   mrrc_frame_acc u_frame_acc (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (advance),
      .rx_byte    (in_byte_ff),
      .frame      (frame)
   );

   // checks on the completed frame
   mrrc_result_chk u_result_chk (
      .frame           (frame),
      .station_address (station_ff),
      .result          (result)
   );

   // only the eighth byte needs room in the result register
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && (!frame.last || out_free);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && frame.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         station_ff   <= STATION_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            station_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance && frame.last) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_result_ff.status;
   assign rsp_chan.register_address = rsp_result_ff.register_address;
   assign rsp_chan.sensor_kind      = rsp_result_ff.sensor_kind;
   assign rsp_chan.channel          = rsp_result_ff.channel;

endmodule

/* hw/rtl/mrrc_frame_acc.sv */
// frame accumulator: byte position, running crc and stored frame bytes
// depends on mrrc_pkg
module mrrc_frame_acc
   import mrrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] rx_byte,
   output frame_type  frame
);

   logic [2:0]  count_ff;
   logic [2:0]  count_in;
   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [7:0]  bytes_ff [0:6];
   logic        last;

   assign last = (count_ff == FRAME_LAST_POS);

   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      if (byte_valid) begin
         if (last) begin
            count_in = '0;
            crc_in   = CRC_INIT;
         end else begin
            count_in = count_ff + 3'd1;
            if (count_ff < CRC_BYTES) begin
               crc_in = crc16_byte(crc_ff, rx_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   // byte seven is used live, never stored
   always_ff @(posedge clock) begin
      if (byte_valid && !last) begin
         bytes_ff[count_ff] <= rx_byte;
      end
   end

   assign frame.last             = last;
   assign frame.station          = bytes_ff[0];
   assign frame.function_code    = bytes_ff[1];
   assign frame.register_address = {bytes_ff[2], bytes_ff[3]};
   assign frame.quantity_low     = bytes_ff[5];
   assign frame.crc_received     = {rx_byte, bytes_ff[6]};
   assign frame.crc_computed     = crc_ff;

endmodule

/* hw/rtl/mrrc_result_chk.sv */
// frame checks in priority order and sensor decode
// depends on mrrc_pkg
module mrrc_result_chk
   import mrrc_pkg::*;
(
   input  frame_type  frame,
   input  logic [7:0] station_address,
   output result_type result
);

   logic [15:0] offset;

   assign offset = frame.register_address - REG_FIRST;

   always_comb begin
      result.status           = STATUS_OK;
      result.register_address = frame.register_address;
      result.sensor_kind      = '0;
      result.channel          = '0;
      if (frame.station != station_address) begin
         result.status = STATUS_ADDR_MISMATCH;
      end else if (frame.crc_received != frame.crc_computed) begin
         result.status = STATUS_CRC_ERROR;
      end else if (frame.function_code != FUNC_READ || frame.quantity_low != QTY_READ) begin
         result.status = STATUS_BAD_FUNCTION;
      end else if (frame.register_address < REG_FIRST ||
                   frame.register_address > REG_LAST) begin
         result.status = STATUS_REG_RANGE;
      end else begin
         result.sensor_kind = offset[5:4];
         result.channel     = offset[3:0] + CHANNEL_BIAS;
      end
   end

endmodule

/* hw/rtl/mrrc_checker.sv */
// port-level assertions for the modbus read request checker, bound to the top
// depends on mrrc_pkg and modbus_read_request_checker_core_defines.svh
`include "modbus_read_request_checker_core_defines.svh"

module mrrc_checker
   import mrrc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_register_address,
   input logic [1:0]  rsp_sensor_kind,
   input logic [3:0]  rsp_channel
);

   `MRRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid,
                     "result dropped while stalled")

   `MRRC_ASSERT_NOW(a_req_backpressure, !req_ready, rsp_valid && !rsp_ready,
                    "input stalled without a held result")

   `MRRC_ASSERT_NOW(a_fail_fields_zero, rsp_valid && rsp_status != STATUS_OK,
                    rsp_sensor_kind == 2'd0 && rsp_channel == 4'd0,
                    "failed transaction carries sensor fields")

   `MRRC_ASSERT_NOW(a_ok_in_range, rsp_valid && rsp_status == STATUS_OK,
                    rsp_register_address >= REG_FIRST && rsp_register_address <= REG_LAST,
                    "ok transaction outside register range")

endmodule

bind modbus_read_request_checker_core mrrc_checker u_mrrc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_status           (rsp_chan.status),
   .rsp_register_address (rsp_chan.register_address),
   .rsp_sensor_kind      (rsp_chan.sensor_kind),
   .rsp_channel          (rsp_chan.channel)
);
